@@ src/bgc_pkg.sv @@
// bgc_pkg: shared types and codes for the barrier gate controller
// holds request/result structs, configuration struct, phase and register codes
// no dependencies
package bgc_pkg;

	// gate phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_OPENING = 3'd1;
	localparam logic [2:0] PH_OPEN    = 3'd2;
	localparam logic [2:0] PH_WAIT    = 3'd3;
	localparam logic [2:0] PH_CLOSING = 3'd4;
	localparam logic [2:0] PH_CLOSED  = 3'd5;
	localparam logic [2:0] PH_BLOCKED = 3'd6;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_SETTLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_HOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SETTLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_REST   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_TMO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_RUNS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REQ_FREE      = 3'd6;

	// register reset values
	localparam logic [15:0] RST_OPEN_SETTLE   = 16'd500;
	localparam logic [15:0] RST_PASS_HOLD     = 16'd2000;
	localparam logic [15:0] RST_CLOSE_SETTLE  = 16'd500;
	localparam logic [15:0] RST_CLOSED_REST   = 16'd1000;
	localparam logic [15:0] RST_BLOCKED_TMO   = 16'd10000;
	localparam logic [7:0]  RST_DEBOUNCE_RUNS = 8'd3;
	localparam logic        RST_REQ_FREE      = 1'b1;

	typedef struct packed {
		logic        car_sensor;
		logic [7:0]  free_spaces;
		logic [15:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] gate_state;
		logic       barrier_open;
		logic       open_pulse;
		logic       close_pulse;
		logic       car_present;
	} out_item_t;

	typedef struct packed {
		logic [15:0] open_settle_ms;
		logic [15:0] pass_hold_ms;
		logic [15:0] close_settle_ms;
		logic [15:0] closed_rest_ms;
		logic [15:0] blocked_timeout_ms;
		logic [7:0]  debounce_runs;
		logic        require_free_space;
	} cfg_regs_t;

endpackage

@@ src/barrier_gate_controller_unit.sv @@
// barrier_gate_controller_unit: top level of the entry barrier gate controller
// depends on bgc_pkg, bgc_cfg_regs, bgc_debounce, bgc_seq
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | in_item  (car_sensor, free_spaces, elapsed_ms)
//  out      | out_valid / out_ready| out_item (gate_state, barrier_open, pulses, car)
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// one request per cycle sustained while out_ready is high; a result leaves from
// the stage 2 result register, whose valid bit drives out_valid
// stage 1 is the input register, stage 2 the result register; the debounce and
// phase state update as a request moves from stage 1 into stage 2
// a stalled out channel holds stage 2; stage 1 still fills, so one more request
// is taken before in_ready drops
// reset clears both valid bits, the gate state (idle, barrier closed) and the
// configuration registers to their defaults
module barrier_gate_controller_unit #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bgc_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bgc_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bgc_pkg::cfg_regs_t cfg;

	// stage 1: input register
	logic              valid_s1;
	bgc_pkg::in_item_t item_s1;
	// stage 2: result register
	logic               valid_s2;
	bgc_pkg::out_item_t result_s2;

	logic               ready_s1;
	logic               adv;
	logic               car_next;
	bgc_pkg::out_item_t result;

	// stage 2 frees up when empty or when its result is taken this cycle
	assign ready_s1 = !valid_s2 || out_ready;
	assign adv      = valid_s1 && ready_s1;
	assign in_ready = !valid_s1 || ready_s1;

	// configuration writes are registered on the clock edge, never stalled
	assign cfg_ready = 1'b1;

	bgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// debounced car level after this request's sample
	bgc_debounce u_deb (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.sample     (item_s1.car_sensor),
		.runs       (cfg.debounce_runs),
		.level_next (car_next)
	);

	// phase sequencer, sees the updated car level
	bgc_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.car         (car_next),
		.free_spaces (item_s1.free_spaces),
		.elapsed_ms  (item_s1.elapsed_ms),
		.cfg         (cfg),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

	// an open command always lands in opening with the barrier up
	a_open_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.open_pulse) |->
		(out_item.gate_state == bgc_pkg::PH_OPENING && out_item.barrier_open))
		else $error("open pulse outside opening");

	// a close command always lands in closing with the barrier down
	a_close_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.close_pulse) |->
		(out_item.gate_state == bgc_pkg::PH_CLOSING && !out_item.barrier_open))
		else $error("close pulse outside closing");

	// barrier is up exactly in opening, open and waiting pass
	a_barrier_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(out_item.barrier_open == (out_item.gate_state == bgc_pkg::PH_OPENING ||
			out_item.gate_state == bgc_pkg::PH_OPEN ||
			out_item.gate_state == bgc_pkg::PH_WAIT)))
		else $error("barrier command disagrees with phase");

	// a request held in stage 1 behind a stalled result stays there
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 request lost under stall");

endmodule

@@ src/bgc_cfg_regs.sv @@
// bgc_cfg_regs: configuration register file of the barrier gate controller
// depends on bgc_pkg
module bgc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]  wr_data,
	output bgc_pkg::cfg_regs_t              cfg
);

	bgc_pkg::cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_settle_ms     <= bgc_pkg::RST_OPEN_SETTLE;
			cfg_q.pass_hold_ms       <= bgc_pkg::RST_PASS_HOLD;
			cfg_q.close_settle_ms    <= bgc_pkg::RST_CLOSE_SETTLE;
			cfg_q.closed_rest_ms     <= bgc_pkg::RST_CLOSED_REST;
			cfg_q.blocked_timeout_ms <= bgc_pkg::RST_BLOCKED_TMO;
			cfg_q.debounce_runs      <= bgc_pkg::RST_DEBOUNCE_RUNS;
			cfg_q.require_free_space <= bgc_pkg::RST_REQ_FREE;
		end else if (wr_en) begin
			unique case (wr_index)
				bgc_pkg::REG_OPEN_SETTLE:   cfg_q.open_settle_ms     <= wr_data;
				bgc_pkg::REG_PASS_HOLD:     cfg_q.pass_hold_ms       <= wr_data;
				bgc_pkg::REG_CLOSE_SETTLE:  cfg_q.close_settle_ms    <= wr_data;
				bgc_pkg::REG_CLOSED_REST:   cfg_q.closed_rest_ms     <= wr_data;
				bgc_pkg::REG_BLOCKED_TMO:   cfg_q.blocked_timeout_ms <= wr_data;
				bgc_pkg::REG_DEBOUNCE_RUNS: cfg_q.debounce_runs      <= wr_data[7:0];
				bgc_pkg::REG_REQ_FREE:      cfg_q.require_free_space <= wr_data[0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/bgc_debounce.sv @@
// bgc_debounce: run-length debounce of the raw car sensor sample
// no dependencies
module bgc_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       sample,
	input  logic [7:0] runs,
	output logic       level_next
);

	logic       last_q;
	logic [7:0] run_q;
	logic       stable_q;
	logic [7:0] run_inc;
	logic       last_d;
	logic [7:0] run_d;
	logic       stable_d;

	always_comb begin
		run_inc  = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
		last_d   = last_q;
		run_d    = run_q;
		stable_d = stable_q;
		if (sample == last_q) begin
			run_d = run_inc;
			if (run_inc >= runs) begin
				stable_d = sample;
			end
		end else begin
			last_d = sample;
			run_d  = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			run_q    <= 8'd0;
			stable_q <= 1'b0;
		end else if (adv) begin
			last_q   <= last_d;
			run_q    <= run_d;
			stable_q <= stable_d;
		end
	end

	assign level_next = stable_d;

endmodule

@@ src/bgc_seq.sv @@
// bgc_seq: gate phase sequencer with saturating per-phase timer
// depends on bgc_pkg
module bgc_seq #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               car,
	input  logic [7:0]         free_spaces,
	input  logic [15:0]        elapsed_ms,
	input  bgc_pkg::cfg_regs_t cfg,
	output bgc_pkg::out_item_t result
);

	localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int unsigned SUM_W = CMP_W + 1;
	localparam logic [SUM_W-1:0] TIMER_MAX = (SUM_W'(1) << TIMER_BITS) - SUM_W'(1);

	logic [2:0]            phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  barrier_q;

	logic [SUM_W-1:0]      sum;
	logic [TIMER_BITS-1:0] timer_sat;
	logic [CMP_W-1:0]      t;
	logic [2:0]            phase_d;
	logic [TIMER_BITS-1:0] timer_d;
	logic                  barrier_d;
	logic                  open_p;
	logic                  close_p;
	logic                  change;
	logic                  space;

	always_comb begin
		sum       = SUM_W'(timer_q) + SUM_W'(elapsed_ms);
		timer_sat = (sum > TIMER_MAX) ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
		t         = CMP_W'(timer_sat);
		space     = (free_spaces != 8'd0);
		phase_d   = phase_q;
		barrier_d = barrier_q;
		open_p    = 1'b0;
		close_p   = 1'b0;
		change    = 1'b0;
		unique case (phase_q)
			bgc_pkg::PH_IDLE: begin
				if (car) begin
					change = 1'b1;
					if (!cfg.require_free_space || space) begin
						barrier_d = 1'b1;
						open_p    = 1'b1;
						phase_d   = bgc_pkg::PH_OPENING;
					end else begin
						phase_d = bgc_pkg::PH_BLOCKED;
					end
				end
			end
			bgc_pkg::PH_OPENING: begin
				if (t >= CMP_W'(cfg.open_settle_ms)) begin
					change  = 1'b1;
					phase_d = bgc_pkg::PH_OPEN;
				end
			end
			bgc_pkg::PH_OPEN: begin
				if (!car) begin
					change  = 1'b1;
					phase_d = bgc_pkg::PH_WAIT;
				end
			end
			bgc_pkg::PH_WAIT: begin
				// a car showing up again is ignored, the hold still runs out
				if (t >= CMP_W'(cfg.pass_hold_ms)) begin
					change    = 1'b1;
					barrier_d = 1'b0;
					close_p   = 1'b1;
					phase_d   = bgc_pkg::PH_CLOSING;
				end
			end
			bgc_pkg::PH_CLOSING: begin
				if (t >= CMP_W'(cfg.close_settle_ms)) begin
					change  = 1'b1;
					phase_d = bgc_pkg::PH_CLOSED;
				end
			end
			bgc_pkg::PH_CLOSED: begin
				if (t >= CMP_W'(cfg.closed_rest_ms)) begin
					change  = 1'b1;
					phase_d = bgc_pkg::PH_IDLE;
				end
			end
			bgc_pkg::PH_BLOCKED: begin
				if (space || t >= CMP_W'(cfg.blocked_timeout_ms)) begin
					change  = 1'b1;
					phase_d = bgc_pkg::PH_IDLE;
				end
			end
			default: begin
				change    = 1'b1;
				barrier_d = 1'b0;
				phase_d   = bgc_pkg::PH_IDLE;
			end
		endcase
		timer_d = change ? '0 : timer_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bgc_pkg::PH_IDLE;
			timer_q   <= '0;
			barrier_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			barrier_q <= barrier_d;
		end
	end

	always_comb begin
		result.gate_state   = phase_d;
		result.barrier_open = barrier_d;
		result.open_pulse   = open_p;
		result.close_pulse  = close_p;
		result.car_present  = car;
	end

endmodule
